>>> rtl/wkd_pkg.sv
// ---------------------------------------------------------------------------
// wkd_pkg: shared definitions for the weighted k-d split grid mapper
// Field widths, register map, sequencer states and round limit.
// ---------------------------------------------------------------------------
package wkd_pkg;

   localparam int DIM_SLOTS        = 3;   // coordinate fields on the result
   localparam int MAX_DIMS_DEFAULT = 3;

   localparam int DIMC_W   = 2;
   localparam int EXT_W    = 16;
   localparam int HALF_W   = EXT_W - 1;
   localparam int WT_W     = 8;
   localparam int NODES_W  = 24;
   localparam int RANK_W   = 24;
   localparam int COORD_W  = 16;
   localparam int IDX_W    = 2;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;

   // upper bound on split rounds for one item
   localparam int ROUND_LIMIT = 64;

   typedef enum logic [2:0] {
      CSR_DIM_COUNT   = 3'd0,
      CSR_EXTENT_0    = 3'd1,
      CSR_EXTENT_1    = 3'd2,
      CSR_EXTENT_2    = 3'd3,
      CSR_WEIGHT_0    = 3'd4,
      CSR_WEIGHT_1    = 3'd5,
      CSR_WEIGHT_2    = 3'd6,
      CSR_TOTAL_NODES = 3'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PICK,
      ST_DIV,
      ST_MUL,
      ST_UPDATE,
      ST_DONE
   } state_type;

endpackage

>>> rtl/wkd_req_if.sv
// ---------------------------------------------------------------------------
// wkd_req_if: request channel
// Valid/ready channel carrying one rank per item.
// ---------------------------------------------------------------------------
interface wkd_req_if;
   logic                           valid;
   logic                           ready;
   logic [wkd_pkg::RANK_W-1:0]     rank;

   modport source (output valid, output rank, input ready);
   modport sink   (input valid, input rank, output ready);
endinterface

>>> rtl/wkd_rsp_if.sv
// ---------------------------------------------------------------------------
// wkd_rsp_if: response channel
// Valid/ready channel carrying one grid coordinate per item.
// ---------------------------------------------------------------------------
interface wkd_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [wkd_pkg::COORD_W-1:0]    coord_0;
   logic [wkd_pkg::COORD_W-1:0]    coord_1;
   logic [wkd_pkg::COORD_W-1:0]    coord_2;

   modport source (output valid, output coord_0, output coord_1, output coord_2,
                   input ready);
   modport sink   (input valid, input coord_0, input coord_1, input coord_2,
                   output ready);
endinterface

>>> rtl/weighted_kd_split_grid_coordinate.sv
// ---------------------------------------------------------------------------
// weighted_kd_split_grid_coordinate: rank to grid coordinate by weighted halving
// Each split round steps through pick, divide, multiply and update;
//   an item with nothing left to cut goes from pick straight to done.
// One item in flight: a new request is taken only back in idle, once the
//   result is loaded; the restoring divider makes one quotient bit a cycle.
// Reset: synchronous, active high; registers return to dim_count 3, extents 1,
//   weights 0, total_nodes 1; sequencer idle, no result pending.
// ---------------------------------------------------------------------------
module weighted_kd_split_grid_coordinate #(
   parameter int MAX_DIMS = wkd_pkg::MAX_DIMS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,

   wkd_req_if.sink                           req_ch,
   wkd_rsp_if.source                         rsp_ch,

   // register port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [wkd_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [wkd_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [wkd_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);

   localparam int ND      = wkd_pkg::DIM_SLOTS;
   localparam int EXT_W   = wkd_pkg::EXT_W;
   localparam int HALF_W  = wkd_pkg::HALF_W;
   localparam int WT_W    = wkd_pkg::WT_W;
   localparam int NODES_W = wkd_pkg::NODES_W;
   localparam int RANK_W  = wkd_pkg::RANK_W;
   localparam int COORD_W = wkd_pkg::COORD_W;
   localparam int IDX_W   = wkd_pkg::IDX_W;
   localparam int DIMC_W  = wkd_pkg::DIMC_W;
   localparam int DW      = wkd_pkg::CSR_DATA_W;
   localparam int ROUND_W = $clog2(wkd_pkg::ROUND_LIMIT);
   localparam int CNT_W   = $clog2(NODES_W);
   localparam int PROD_W  = NODES_W + HALF_W;
   localparam int CMP_W   = EXT_W + WT_W;

   // -----------------------------------------------------------------------
   // Configuration registers
   // -----------------------------------------------------------------------
   logic [DIMC_W-1:0]  dim_count_ff;
   logic [EXT_W-1:0]   cfg_ext_ff [ND];
   logic [WT_W-1:0]    cfg_wt_ff  [ND];
   logic [NODES_W-1:0] total_nodes_ff;

   logic               csr_wr;
   wkd_pkg::csr_index_type csr_idx;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = wkd_pkg::csr_index_type'(paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_count_ff   <= DIMC_W'(3);
         total_nodes_ff <= NODES_W'(1);
         for (int k = 0; k < ND; k++) begin
            cfg_ext_ff[k] <= EXT_W'(1);
            cfg_wt_ff[k]  <= '0;
         end
      end else if (csr_wr) begin
         unique case (csr_idx)
            wkd_pkg::CSR_DIM_COUNT:   dim_count_ff   <= pwdata[DIMC_W-1:0];
            wkd_pkg::CSR_EXTENT_0:    cfg_ext_ff[0]  <= pwdata[EXT_W-1:0];
            wkd_pkg::CSR_EXTENT_1:    cfg_ext_ff[1]  <= pwdata[EXT_W-1:0];
            wkd_pkg::CSR_EXTENT_2:    cfg_ext_ff[2]  <= pwdata[EXT_W-1:0];
            wkd_pkg::CSR_WEIGHT_0:    cfg_wt_ff[0]   <= pwdata[WT_W-1:0];
            wkd_pkg::CSR_WEIGHT_1:    cfg_wt_ff[1]   <= pwdata[WT_W-1:0];
            wkd_pkg::CSR_WEIGHT_2:    cfg_wt_ff[2]   <= pwdata[WT_W-1:0];
            wkd_pkg::CSR_TOTAL_NODES: total_nodes_ff <= pwdata[NODES_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         wkd_pkg::CSR_DIM_COUNT:   prdata = DW'(dim_count_ff);
         wkd_pkg::CSR_EXTENT_0:    prdata = DW'(cfg_ext_ff[0]);
         wkd_pkg::CSR_EXTENT_1:    prdata = DW'(cfg_ext_ff[1]);
         wkd_pkg::CSR_EXTENT_2:    prdata = DW'(cfg_ext_ff[2]);
         wkd_pkg::CSR_WEIGHT_0:    prdata = DW'(cfg_wt_ff[0]);
         wkd_pkg::CSR_WEIGHT_1:    prdata = DW'(cfg_wt_ff[1]);
         wkd_pkg::CSR_WEIGHT_2:    prdata = DW'(cfg_wt_ff[2]);
         wkd_pkg::CSR_TOTAL_NODES: prdata = DW'(total_nodes_ff);
         default:                  prdata = '0;
      endcase
   end

   // dimensions in use, clamped to what this build supports
   logic [DIMC_W-1:0] used;
   assign used = (dim_count_ff > DIMC_W'(MAX_DIMS)) ? DIMC_W'(MAX_DIMS) : dim_count_ff;

   // -----------------------------------------------------------------------
   // Working state of the current item
   // -----------------------------------------------------------------------
   wkd_pkg::state_type state_ff, state_in;

   logic [EXT_W-1:0]   ext_ff   [ND];   // current extents
   logic [EXT_W-1:0]   ext_in   [ND];
   logic [COORD_W-1:0] coord_ff [ND];
   logic [COORD_W-1:0] coord_in [ND];
   logic [RANK_W-1:0]  rank_ff, rank_in;
   logic [NODES_W-1:0] remain_ff, remain_in;
   logic [ROUND_W-1:0] round_ff, round_in;

   // dimension pick: one candidate examined per cycle
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [IDX_W-1:0]   best_ff, best_in;
   logic               best_valid_ff, best_valid_in;
   logic               best_zero_ff, best_zero_in;

   // cut dimension and divider
   logic [IDX_W-1:0]   cut_ff, cut_in;
   logic [EXT_W-1:0]   div_e_ff, div_e_in;
   logic [NODES_W-1:0] dq_ff, dq_in;      // dividend shifting out, quotient in
   logic [EXT_W-1:0]   rem_ff, rem_in;
   logic [CNT_W-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [NODES_W-1:0] share_ff, share_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COORD_W-1:0] rsp_coord_ff [ND];
   logic [COORD_W-1:0] rsp_coord_in [ND];

   // -----------------------------------------------------------------------
   // Pick step: zero weight wins outright (first one), otherwise the largest
   // extent/weight by cross-multiplication, ties to the lower index.
   // -----------------------------------------------------------------------
   logic               cand_ok;
   logic [CMP_W-1:0]   lhs, rhs;
   logic               pick_found;

   assign cand_ok = (DIMC_W'(idx_ff) < used) && (ext_ff[idx_ff] > EXT_W'(1));
   assign lhs     = CMP_W'(ext_ff[idx_ff]) * CMP_W'(cfg_wt_ff[best_ff]);
   assign rhs     = CMP_W'(ext_ff[best_ff]) * CMP_W'(cfg_wt_ff[idx_ff]);

   always_comb begin
      best_in       = best_ff;
      best_valid_in = best_valid_ff;
      best_zero_in  = best_zero_ff;
      if (cand_ok) begin
         if (cfg_wt_ff[idx_ff] == '0) begin
            if (!best_zero_ff) begin
               best_in       = idx_ff;
               best_valid_in = 1'b1;
               best_zero_in  = 1'b1;
            end
         end else if (!best_zero_ff) begin
            if (!best_valid_ff) begin
               best_in       = idx_ff;
               best_valid_in = 1'b1;
            end else if (lhs > rhs) begin
               best_in = idx_ff;
            end
         end
      end
   end

   assign pick_found = best_valid_in;

   // -----------------------------------------------------------------------
   // Divider step (restoring, one quotient bit a cycle), share multiply
   // -----------------------------------------------------------------------
   logic [EXT_W:0]     trial;
   logic               trial_ge;
   logic [HALF_W-1:0]  half;
   logic [PROD_W-1:0]  prod;
   logic               last_idx;
   logic               out_load;

   assign trial    = {rem_ff, dq_ff[NODES_W-1]};
   assign trial_ge = trial >= {1'b0, div_e_ff};
   assign half     = div_e_ff[EXT_W-1:1];
   // share never exceeds the remaining count, so the low bits hold it whole
   assign prod     = PROD_W'(dq_ff) * PROD_W'(half);
   assign last_idx = idx_ff == IDX_W'(ND - 1);
   assign out_load = (state_ff == wkd_pkg::ST_DONE) && (!rsp_valid_ff || rsp_ch.ready);

   assign req_ch.ready = state_ff == wkd_pkg::ST_IDLE;

   // -----------------------------------------------------------------------
   // Sequencer: next state
   // -----------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wkd_pkg::ST_IDLE:
            if (req_ch.valid) state_in = wkd_pkg::ST_PICK;
         wkd_pkg::ST_PICK:
            if (last_idx) state_in = pick_found ? wkd_pkg::ST_DIV : wkd_pkg::ST_DONE;
         wkd_pkg::ST_DIV:
            if (bit_cnt_ff == '0) state_in = wkd_pkg::ST_MUL;
         wkd_pkg::ST_MUL:
            state_in = wkd_pkg::ST_UPDATE;
         wkd_pkg::ST_UPDATE:
            state_in = (round_ff == ROUND_W'(wkd_pkg::ROUND_LIMIT - 1)) ?
                       wkd_pkg::ST_DONE : wkd_pkg::ST_PICK;
         wkd_pkg::ST_DONE:
            if (out_load) state_in = wkd_pkg::ST_IDLE;
         default:
            state_in = wkd_pkg::ST_IDLE;
      endcase
   end

   // -----------------------------------------------------------------------
   // Sequencer: datapath updates
   // -----------------------------------------------------------------------
   always_comb begin
      ext_in        = ext_ff;
      coord_in      = coord_ff;
      rank_in       = rank_ff;
      remain_in     = remain_ff;
      round_in      = round_ff;
      idx_in        = idx_ff;
      cut_in        = cut_ff;
      div_e_in      = div_e_ff;
      dq_in         = dq_ff;
      rem_in        = rem_ff;
      bit_cnt_in    = bit_cnt_ff;
      share_in      = share_ff;
      rsp_coord_in  = rsp_coord_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;

      unique case (state_ff)
         wkd_pkg::ST_IDLE: begin
            // take a new item and start from the configured grid
            rank_in   = req_ch.rank;
            remain_in = total_nodes_ff;
            round_in  = '0;
            idx_in    = '0;
            for (int k = 0; k < ND; k++) begin
               ext_in[k]   = cfg_ext_ff[k];
               coord_in[k] = '0;
            end
         end
         wkd_pkg::ST_PICK: begin
            idx_in = last_idx ? '0 : idx_ff + IDX_W'(1);
            if (last_idx) begin
               // load the divider: remaining / extent of the chosen dimension
               cut_in     = best_in;
               div_e_in   = ext_ff[best_in];
               dq_in      = remain_ff;
               rem_in     = '0;
               bit_cnt_in = CNT_W'(NODES_W - 1);
            end
         end
         wkd_pkg::ST_DIV: begin
            rem_in     = trial_ge ? EXT_W'(trial - {1'b0, div_e_ff}) : trial[EXT_W-1:0];
            dq_in      = {dq_ff[NODES_W-2:0], trial_ge};
            bit_cnt_in = bit_cnt_ff - CNT_W'(1);
         end
         wkd_pkg::ST_MUL: begin
            share_in = prod[NODES_W-1:0];
         end
         wkd_pkg::ST_UPDATE: begin
            round_in = round_ff + ROUND_W'(1);
            if (rank_ff < share_ff) begin
               ext_in[cut_ff] = EXT_W'(half);
               remain_in      = share_ff;
            end else begin
               ext_in[cut_ff]   = div_e_ff - EXT_W'(half);
               coord_in[cut_ff] = coord_ff[cut_ff] + COORD_W'(half);
               rank_in          = rank_ff - share_ff;
               remain_in        = remain_ff - share_ff;
            end
         end
         wkd_pkg::ST_DONE: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               rsp_coord_in = coord_ff;
            end
         end
         default: ;
      endcase
   end

   // best-so-far is cleared at the start of every pick pass
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= wkd_pkg::ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         idx_ff        <= '0;
         best_ff       <= '0;
         best_valid_ff <= 1'b0;
         best_zero_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         if (state_ff == wkd_pkg::ST_PICK && !last_idx) begin
            best_ff       <= best_in;
            best_valid_ff <= best_valid_in;
            best_zero_ff  <= best_zero_in;
         end else begin
            best_ff       <= '0;
            best_valid_ff <= 1'b0;
            best_zero_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      ext_ff       <= ext_in;
      coord_ff     <= coord_in;
      rank_ff      <= rank_in;
      remain_ff    <= remain_in;
      round_ff     <= round_in;
      cut_ff       <= cut_in;
      div_e_ff     <= div_e_in;
      dq_ff        <= dq_in;
      rem_ff       <= rem_in;
      bit_cnt_ff   <= bit_cnt_in;
      share_ff     <= share_in;
      rsp_coord_ff <= rsp_coord_in;
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.coord_0 = rsp_coord_ff[0];
   assign rsp_ch.coord_1 = rsp_coord_ff[1];
   assign rsp_ch.coord_2 = rsp_coord_ff[2];

endmodule
